// ===== src/plmw_pkg.sv =====
// Package for the piecewise linear mass warp: sizes, codes, state and divider types.
package plmw_pkg;

  localparam int MAX_ANCHORS     = 64;
  localparam int IDX_W           = $clog2(MAX_ANCHORS);
  localparam int CNT_W           = IDX_W + 1;
  localparam int MASS_W          = 32;
  localparam int SLOPE_W         = 32;
  localparam int SLOPE_FRAC_BITS = 24;
  localparam int ANC_W           = 2 * MASS_W;

  // dividend is |dy| << 24 plus |dx| / 2, one bit wider for the carry
  localparam int DVD_W      = MASS_W + SLOPE_FRAC_BITS + 1;
  localparam int DIV_STEPS  = DVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(1) << SLOPE_FRAC_BITS;
  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_WARP   = 2'd2,
    MODE_NOP    = 2'd3
  } plmw_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_DIV,
    S_WARP,
    S_WALK,
    S_WALK_CMP,
    S_SEG_RD,
    S_MUL,
    S_ADD
  } plmw_state_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [MASS_W-1:0] quot;
  } plmw_div_res_t;

endpackage

// ===== src/plmw_ram.sv =====
// Generic single write, single read RAM with registered read data.
module plmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

// ===== src/plmw_div.sv =====
// Restoring divider for the segment slope, one quotient bit per cycle.
module plmw_div import plmw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [MASS_W-1:0]  divisor,
  output plmw_div_res_t      res
);

  logic [DVD_W-1:0]     dvd_r;
  logic [MASS_W-1:0]    dsr_r;
  logic [MASS_W-1:0]    rem_r;
  logic [MASS_W-1:0]    quot_r;
  logic                 ovf_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [MASS_W:0] shifted;
  logic [MASS_W:0] trial;
  logic            qbit;

  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};
  assign qbit    = ~trial[MASS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
      ovf_r  <= 1'b0;
    end else if (run_r) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r  <= qbit ? trial[MASS_W-1:0] : shifted[MASS_W-1:0];
      quot_r <= {quot_r[MASS_W-2:0], qbit};
      // a bit pushed out of the top means the quotient is past 32 bits
      ovf_r  <= ovf_r | quot_r[MASS_W-1];
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

endmodule

// ===== src/piecewise_linear_mass_warp.sv =====
// Top level of the piecewise linear mass warp: sequencer, anchor tables, warp datapath.
//
// Usage
//   A command word (in_mode, in_mass_in, in_target_mass) is taken at a rising edge
//   with start high and busy low. Clear (mode 0) and no-op (mode 3) complete in
//   that edge and give no result; busy stays low. Append (mode 1) and warp
//   (mode 2) each give one result word on out_* for exactly one cycle, marked by
//   out_valid. The receiver cannot stall: the word is taken in that cycle.
//   busy drops in the cycle the result shows, so the next command may be given
//   at once; the result sits in its own output register.
// Sequence (states from the accepting edge to the result)
//   warp, fewer than two anchors: result straight from the warp state
//   warp, mass at or outside the outer anchors: segment read, multiply, add
//   warp, interior: the walk reads the next anchor and steps the segment pointer
//     until the last segment or a failed compare, then segment read, multiply, add;
//     with masses in ascending order the pointer moves a step or so per warp
//   append, first anchor, full table or equal source masses: result straight away
//   append with a slope: waits on the bit-serial divider (57 quotient bits)
// Reset
//   Synchronous, active low: the anchor count, segment pointer and drop flag
//   clear. The anchor and slope tables are not cleared; entries above the count
//   are never read.
module piecewise_linear_mass_warp import plmw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic [MASS_W-1:0] in_mass_in,
  input  logic [MASS_W-1:0] in_target_mass,
  output logic              out_valid,
  output logic [MASS_W-1:0] out_warped_mass,
  output logic              out_saturated,
  output logic              out_anchors_dropped
);

  localparam int SUM_W = MASS_W + SLOPE_FRAC_BITS - 14; // holds target +/- 40-bit term
  localparam int P_W   = 2 * MASS_W - SLOPE_FRAC_BITS;

  // control state
  plmw_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             drop_r, drop_nxt;

  // payload registers
  logic [MASS_W-1:0]   x_r, tgt_r;
  logic [MASS_W-1:0]   x0_r, y0_r, xl_r, yl_r;   // first and last anchor
  logic [IDX_W-1:0]    seg_r, seg_nxt;
  logic [2*MASS_W-1:0] prod_r;
  logic                neg_r, slope_neg_r;
  logic                out_valid_r;
  logic [MASS_W-1:0]   out_w_r;
  logic                out_sat_r, out_drop_r;

  // table ports
  logic               anc_we, slp_we, rd_en;
  logic [IDX_W-1:0]   anc_wa, slp_wa, rd_addr;
  logic [ANC_W-1:0]   anc_wd, anc_rd;
  logic [SLOPE_W-1:0] slp_wd, slp_rd;
  logic [MASS_W-1:0]  rd_src, rd_tgt;

  // divider
  logic          div_start;
  logic [DVD_W-1:0] div_dvd;
  plmw_div_res_t div_res;

  // result of this cycle
  logic              emit;
  logic [MASS_W-1:0] res_w;
  logic              res_clip;

  // decisions
  logic [CNT_W-1:0]  km2;
  logic [IDX_W-1:0]  km2_idx;
  logic              k_zero, k_one, full, x_le_x0, x_ge_xl, walk_more, walk_adv;
  logic [MASS_W:0]   adx, ady;            // append differences, signed
  logic [MASS_W-1:0] amx, amy;
  logic              dx_zero;
  logic [MASS_W:0]   wdx;                 // warp difference, signed
  logic [MASS_W-1:0] wmx, wma;
  logic              wneg;
  logic [MASS_W+1:0] one_sum;
  logic [P_W-1:0]    p_term;
  logic [SUM_W-1:0]  seg_sum;
  logic [MASS_W-1:0] sat_w;
  logic              sat_c;
  logic [MASS_W-1:0] one_w;
  logic              one_c;
  logic [SLOPE_W-1:0] q_slope;
  logic              q_clip;

  assign busy   = (state_r != S_IDLE);
  assign rd_src = anc_rd[ANC_W-1:MASS_W];
  assign rd_tgt = anc_rd[MASS_W-1:0];

  assign km2       = count_r - CNT_W'(2);
  assign km2_idx   = km2[IDX_W-1:0];
  assign k_zero    = (count_r == '0);
  assign k_one     = (count_r == CNT_W'(1));
  assign full      = (count_r >= CNT_W'(MAX_ANCHORS));
  assign x_le_x0   = (x_r <= x0_r);
  assign x_ge_xl   = (x_r >= xl_r);
  assign walk_more = ({1'b0, ptr_r} < km2);
  assign walk_adv  = (x_r > rd_src);

  // append: slope magnitude and sign against the last anchor
  assign adx     = {1'b0, x_r} - {1'b0, xl_r};
  assign ady     = {1'b0, tgt_r} - {1'b0, yl_r};
  assign amx     = adx[MASS_W] ? MASS_W'(-adx) : adx[MASS_W-1:0];
  assign amy     = ady[MASS_W] ? MASS_W'(-ady) : ady[MASS_W-1:0];
  assign dx_zero = (adx == '0);
  // rounding to nearest: add half the divisor before dividing
  assign div_dvd = DVD_W'({amy, SLOPE_FRAC_BITS'(0)}) + DVD_W'(amx[MASS_W-1:1]);

  // slope clipping to signed Q8.24
  always_comb begin
    if (!slope_neg_r) begin
      q_clip  = div_res.ovf | div_res.quot[MASS_W-1];
      q_slope = q_clip ? SLOPE_MAX : div_res.quot;
    end else begin
      q_clip  = div_res.ovf | (div_res.quot > SLOPE_MIN);
      q_slope = q_clip ? SLOPE_MIN : SLOPE_W'(-div_res.quot);
    end
  end

  // warp: magnitudes for the multiplier
  assign wdx  = {1'b0, x_r} - {1'b0, rd_src};
  assign wmx  = wdx[MASS_W] ? MASS_W'(-wdx) : wdx[MASS_W-1:0];
  assign wma  = slp_rd[SLOPE_W-1] ? MASS_W'(-slp_rd) : slp_rd;
  assign wneg = wdx[MASS_W] ^ slp_rd[SLOPE_W-1];

  // one anchor: constant shift
  assign one_sum = {2'b00, x_r} + {2'b00, y0_r} - {2'b00, x0_r};
  always_comb begin
    if (one_sum[MASS_W+1]) begin
      one_w = '0;
      one_c = 1'b1;
    end else if (one_sum[MASS_W]) begin
      one_w = '1;
      one_c = 1'b1;
    end else begin
      one_w = one_sum[MASS_W-1:0];
      one_c = 1'b0;
    end
  end

  // product has 24 fraction bits; round half away from zero on the magnitude
  assign p_term  = P_W'((prod_r + ((2*MASS_W)'(1) << (SLOPE_FRAC_BITS - 1)))
                        >> SLOPE_FRAC_BITS);
  assign seg_sum = neg_r ? SUM_W'(rd_tgt) - SUM_W'(p_term) : SUM_W'(rd_tgt) + SUM_W'(p_term);
  always_comb begin
    if (seg_sum[SUM_W-1]) begin
      sat_w = '0;
      sat_c = 1'b1;
    end else if (seg_sum[SUM_W-2:MASS_W] != '0) begin
      sat_w = '1;
      sat_c = 1'b1;
    end else begin
      sat_w = seg_sum[MASS_W-1:0];
      sat_c = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (plmw_mode_t'(in_mode))
            MODE_APPEND: state_nxt = S_APPEND;
            MODE_WARP:   state_nxt = S_WARP;
            MODE_CLEAR:  state_nxt = S_IDLE;
            MODE_NOP:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_APPEND: begin
        priority if (full || k_zero || dx_zero) state_nxt = S_IDLE;
        else                                   state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) state_nxt = S_IDLE;
      end
      S_WARP: begin
        priority if (k_zero || k_one)      state_nxt = S_IDLE;
        else if (x_le_x0 || x_ge_xl)      state_nxt = S_SEG_RD;
        else                              state_nxt = S_WALK;
      end
      S_WALK: begin
        state_nxt = walk_more ? S_WALK_CMP : S_SEG_RD;
      end
      S_WALK_CMP: begin
        state_nxt = walk_adv ? S_WALK : S_SEG_RD;
      end
      S_SEG_RD: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_ADD;
      S_ADD:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    drop_nxt  = drop_r;
    seg_nxt   = seg_r;
    anc_we    = 1'b0;
    anc_wa    = count_r[IDX_W-1:0];
    anc_wd    = {x_r, tgt_r};
    slp_we    = 1'b0;
    slp_wa    = IDX_W'(count_r - CNT_W'(1));
    slp_wd    = q_slope;
    rd_en     = 1'b0;
    rd_addr   = seg_r;
    div_start = 1'b0;
    emit      = 1'b0;
    res_w     = '0;
    res_clip  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start && (plmw_mode_t'(in_mode) == MODE_CLEAR)) begin
          count_nxt = '0;
          ptr_nxt   = '0;
          drop_nxt  = 1'b0;
        end
      end
      S_APPEND: begin
        priority if (full) begin
          drop_nxt = 1'b1;
          emit     = 1'b1;
        end else begin
          anc_we = 1'b1;
          priority if (k_zero) begin
            count_nxt = count_r + 1'b1;
            emit      = 1'b1;
          end else if (dx_zero) begin
            slp_we    = 1'b1;
            slp_wd    = SLOPE_ONE;
            count_nxt = count_r + 1'b1;
            emit      = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          slp_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          emit      = 1'b1;
          res_clip  = q_clip;
        end
      end
      S_WARP: begin
        priority if (k_zero) begin
          emit  = 1'b1;
          res_w = x_r;
        end else if (k_one) begin
          emit     = 1'b1;
          res_w    = one_w;
          res_clip = one_c;
        end else if (x_le_x0) begin
          seg_nxt = '0;
        end else if (x_ge_xl) begin
          seg_nxt = km2_idx;
        end else begin
          ptr_nxt = ({1'b0, ptr_r} > km2) ? km2_idx : ptr_r;
        end
      end
      S_WALK: begin
        if (walk_more) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + 1'b1;
        end else begin
          seg_nxt = ptr_r;
        end
      end
      S_WALK_CMP: begin
        if (walk_adv) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          seg_nxt = ptr_r;
        end
      end
      S_SEG_RD: begin
        rd_en   = 1'b1;
        rd_addr = seg_r;
      end
      S_MUL: begin
      end
      S_ADD: begin
        emit     = 1'b1;
        res_w    = sat_w;
        res_clip = sat_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    if (start && !busy) begin
      x_r   <= in_mass_in;
      tgt_r <= in_target_mass;
    end
    if (anc_we) begin
      xl_r <= x_r;
      yl_r <= tgt_r;
      if (k_zero) begin
        x0_r <= x_r;
        y0_r <= tgt_r;
      end
    end
    if (div_start) begin
      slope_neg_r <= adx[MASS_W] ^ ady[MASS_W];
    end
    if (state_r == S_MUL) begin
      prod_r <= wmx * wma;
      neg_r  <= wneg;
    end
    if (emit) begin
      out_w_r    <= res_w;
      out_sat_r  <= res_clip;
      out_drop_r <= drop_nxt;
    end
  end

  plmw_ram #(
    .WIDTH(ANC_W),
    .DEPTH(MAX_ANCHORS)
  ) u_anchor_ram (
    .clk (clk),
    .we  (anc_we),
    .wa  (anc_wa),
    .wd  (anc_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (anc_rd)
  );

  plmw_ram #(
    .WIDTH(SLOPE_W),
    .DEPTH(MAX_ANCHORS)
  ) u_slope_ram (
    .clk (clk),
    .we  (slp_we),
    .wa  (slp_wa),
    .wd  (slp_wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .rd  (slp_rd)
  );

  plmw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (amx),
    .res      (div_res)
  );

  assign out_valid           = out_valid_r;
  assign out_warped_mass     = out_w_r;
  assign out_saturated       = out_sat_r;
  assign out_anchors_dropped = out_drop_r;

endmodule
